### rtl/core/drfp_pkg.sv
`default_nettype none

package drfp_pkg;

  // Reply codes and framing constants of the display link.
  localparam logic [7:0] CODE_NUMBER = 8'h71;
  localparam logic [7:0] CODE_STRING = 8'h70;
  localparam logic [7:0] TERM_BYTE   = 8'hFF;
  localparam logic [2:0] NUM_BYTES   = 3'd4;
  localparam logic [2:0] TERM_LEN    = 3'd3;
  localparam logic [1:0] RUN_LEN     = 2'd3;

  // Result kinds.
  localparam logic KIND_CHAR  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  string_char;
    logic [7:0]  reply_code;
    logic [31:0] number_value;
    logic        frame_status;
  } drfp_result_t;

endpackage

`default_nettype wire

### rtl/core/display_response_frame_parser.sv
`default_nettype none

// A byte accepted into the input register is parsed once the result register is
// free, and its result transaction, if any, is then registered onto the out_ ports.
// Throughput: one byte per cycle, set by the single parse stage between the
// input register and the result register; out_stall back-pressures in_stall.
// Reset (rst_n low, synchronous): parser waits for a code byte, both registers empty.

module display_response_frame_parser (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_rx_byte,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_string_char,
  output logic [7:0]  out_reply_code,
  output logic [31:0] out_number_value,
  output logic        out_frame_status
);
  import drfp_pkg::*;

  // Input register. It holds one received byte until the parser takes it.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  logic         out_free;
  logic         step;
  logic         res_valid;
  drfp_result_t res;
  drfp_result_t out_res;

  // The parser consumes the held byte whenever the result register can take
  // whatever that byte produces. A byte that yields no result still needs the
  // result register to be free so that ordering is kept simple.
  assign step     = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (step) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // Frame state machine: code, number bytes, terminator bytes, string bytes.
  drfp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (s1_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register. It presents each result transaction until it is taken.
  drfp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_result_kind  = out_res.result_kind;
  assign out_string_char  = out_res.string_char;
  assign out_reply_code   = out_res.reply_code;
  assign out_number_value = out_res.number_value;
  assign out_frame_status = out_res.frame_status;

endmodule

`default_nettype wire

### rtl/core/drfp_parse.sv
`default_nettype none

module drfp_parse (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   step,
  input  wire  [7:0]            rx_byte,
  output logic                  res_valid,
  output drfp_pkg::drfp_result_t res
);
  import drfp_pkg::*;

  typedef enum logic [1:0] {
    PH_CODE   = 2'd0,
    PH_NUMBER = 2'd1,
    PH_TERM   = 2'd2,
    PH_STRING = 2'd3
  } phase_t;

  phase_t      phase_r,     phase_nxt;
  logic [7:0]  held_code_r, held_code_nxt;
  logic [2:0]  byte_count_r, byte_count_nxt;
  logic [31:0] number_accum_r, number_accum_nxt;
  logic [7:0]  term_and_r,  term_and_nxt;
  logic [1:0]  ff_run_r,    ff_run_nxt;

  logic [2:0]  count_inc;
  logic [1:0]  run_inc;
  logic [7:0]  term_and_new;

  assign count_inc    = byte_count_r + 3'd1;
  assign run_inc      = ff_run_r + 2'd1;
  assign term_and_new = term_and_r & rx_byte;

  always_comb begin
    phase_nxt        = phase_r;
    held_code_nxt    = held_code_r;
    byte_count_nxt   = byte_count_r;
    number_accum_nxt = number_accum_r;
    term_and_nxt     = term_and_r;
    ff_run_nxt       = ff_run_r;
    res_valid        = 1'b0;
    res              = '0;

    unique case (phase_r)
      PH_CODE: begin
        held_code_nxt    = rx_byte;
        byte_count_nxt   = '0;
        number_accum_nxt = '0;
        term_and_nxt     = TERM_BYTE;
        ff_run_nxt       = '0;
        if (rx_byte == CODE_NUMBER) begin
          phase_nxt = PH_NUMBER;
        end else if (rx_byte == CODE_STRING) begin
          phase_nxt = PH_STRING;
        end else begin
          phase_nxt = PH_TERM;
        end
      end
      PH_NUMBER: begin
        // Little-endian: byte k lands at bit 8*k.
        number_accum_nxt = number_accum_r |
                           (32'(rx_byte) << {byte_count_r[1:0], 3'b000});
        if (count_inc >= NUM_BYTES) begin
          byte_count_nxt = '0;
          phase_nxt      = PH_TERM;
        end else begin
          byte_count_nxt = count_inc;
        end
      end
      PH_TERM: begin
        if (count_inc >= TERM_LEN) begin
          res_valid        = 1'b1;
          res.result_kind  = KIND_FRAME;
          res.reply_code   = held_code_r;
          res.number_value = (held_code_r == CODE_NUMBER) ? number_accum_r : '0;
          res.frame_status = (term_and_new != TERM_BYTE);
          phase_nxt        = PH_CODE;
          byte_count_nxt   = '0;
          number_accum_nxt = '0;
          term_and_nxt     = TERM_BYTE;
        end else begin
          byte_count_nxt = count_inc;
          term_and_nxt   = term_and_new;
        end
      end
      PH_STRING: begin
        if (rx_byte != TERM_BYTE) begin
          // A short run of 0xFF before this byte is dropped.
          ff_run_nxt      = '0;
          res_valid       = 1'b1;
          res.result_kind = KIND_CHAR;
          res.string_char = rx_byte;
        end else if (run_inc == RUN_LEN) begin
          ff_run_nxt      = '0;
          phase_nxt       = PH_CODE;
          res_valid       = 1'b1;
          res.result_kind = KIND_FRAME;
          res.reply_code  = held_code_r;
        end else begin
          ff_run_nxt = run_inc;
        end
      end
      default: begin
        phase_nxt = PH_CODE;
      end
    endcase

    if (!step) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_CODE;
      held_code_r    <= '0;
      byte_count_r   <= '0;
      number_accum_r <= '0;
      term_and_r     <= TERM_BYTE;
      ff_run_r       <= '0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      held_code_r    <= held_code_nxt;
      byte_count_r   <= byte_count_nxt;
      number_accum_r <= number_accum_nxt;
      term_and_r     <= term_and_nxt;
      ff_run_r       <= ff_run_nxt;
    end
  end

`ifndef SYNTHESIS
  a_res_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> step)
    else $error("result produced without a byte being processed");

  a_frame_returns_to_code: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.result_kind == KIND_FRAME) |=> (phase_r == PH_CODE))
    else $error("parser did not return to code phase after frame end");

  a_char_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.result_kind == KIND_CHAR) |->
      (res.reply_code == 8'h00 && res.number_value == 32'h0 && !res.frame_status))
    else $error("character result carries frame fields");

  a_number_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_NUMBER) |-> (byte_count_r < NUM_BYTES))
    else $error("number byte count out of range");

  a_term_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_TERM) |-> (byte_count_r < TERM_LEN))
    else $error("terminator byte count out of range");
`endif

endmodule

`default_nettype wire

### rtl/core/drfp_out_stage.sv
`default_nettype none

module drfp_out_stage (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    load,
  input  wire drfp_pkg::drfp_result_t res,
  input  wire                    out_stall,
  output logic                   out_free,
  output logic                   out_valid,
  output drfp_pkg::drfp_result_t out_res
);
  import drfp_pkg::*;

  logic         valid_r;
  drfp_result_t res_r;

  // The register can take a new result when empty or being drained.
  assign out_free  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

### tb/sv/display_response_frame_parser_checker.sv
`default_nettype none

// Watches both channels of the frame parser. It predicts every result from
// the accepted bytes and compares each result transaction with the oldest
// prediction.
module display_response_frame_parser_checker
  import drfp_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire  [7:0]  in_rx_byte,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire         out_result_kind,
  input  wire  [7:0]  out_string_char,
  input  wire  [7:0]  out_reply_code,
  input  wire  [31:0] out_number_value,
  input  wire         out_frame_status,
  output int          fail_count,
  output int          results_owed
);

  typedef enum logic [1:0] {
    WAIT_CODE,
    TAKE_NUMBER,
    TAKE_TERM,
    TAKE_STRING
  } parse_phase_e;

  parse_phase_e phase;
  logic [7:0]   frame_code;
  logic [2:0]   bytes_taken;
  logic [31:0]  number_acc;
  logic [7:0]   term_and;
  logic [1:0]   ff_count;

  drfp_result_t awaited_results[$];

  function automatic void reset_parser();
    phase       = WAIT_CODE;
    frame_code  = '0;
    bytes_taken = '0;
    number_acc  = '0;
    term_and    = TERM_BYTE;
    ff_count    = '0;
  endfunction

  // Advances the parser by one byte. Returns 1 when the byte yields a result.
  function automatic bit parse_byte(input logic [7:0] b, output drfp_result_t res);
    bit done;
    done = 1'b0;
    res  = '0;
    case (phase)
      WAIT_CODE: begin
        frame_code  = b;
        bytes_taken = '0;
        number_acc  = '0;
        term_and    = TERM_BYTE;
        ff_count    = '0;
        if (b == CODE_NUMBER) begin
          phase = TAKE_NUMBER;
        end else if (b == CODE_STRING) begin
          phase = TAKE_STRING;
        end else begin
          phase = TAKE_TERM;
        end
      end
      TAKE_NUMBER: begin
        // Little-endian: the first number byte is the least significant.
        number_acc  = number_acc | (32'(b) << (8 * bytes_taken[1:0]));
        bytes_taken = bytes_taken + 3'd1;
        if (bytes_taken >= NUM_BYTES) begin
          bytes_taken = '0;
          phase       = TAKE_TERM;
        end
      end
      TAKE_TERM: begin
        term_and    = term_and & b;
        bytes_taken = bytes_taken + 3'd1;
        if (bytes_taken >= TERM_LEN) begin
          res.result_kind  = KIND_FRAME;
          res.reply_code   = frame_code;
          res.number_value = (frame_code == CODE_NUMBER) ? number_acc : 32'd0;
          res.frame_status = (term_and != TERM_BYTE);
          done        = 1'b1;
          phase       = WAIT_CODE;
          bytes_taken = '0;
          number_acc  = '0;
          term_and    = TERM_BYTE;
        end
      end
      TAKE_STRING: begin
        if (b != TERM_BYTE) begin
          // A short run of 0xFF before a character is simply dropped.
          ff_count        = '0;
          res.result_kind = KIND_CHAR;
          res.string_char = b;
          done            = 1'b1;
        end else begin
          ff_count = ff_count + 2'd1;
          if (ff_count >= RUN_LEN) begin
            ff_count        = '0;
            phase           = WAIT_CODE;
            res.result_kind = KIND_FRAME;
            res.reply_code  = frame_code;
            done            = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return done;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    drfp_result_t want;
    drfp_result_t predicted;
    if (!rst_n) begin
      reset_parser();
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0b char 0x%0h code 0x%0h",
                   $time, out_result_kind, out_string_char, out_reply_code);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("result_kind", 32'(want.result_kind), 32'(out_result_kind));
          check_field("string_char", 32'(want.string_char), 32'(out_string_char));
          check_field("reply_code", 32'(want.reply_code), 32'(out_reply_code));
          check_field("number_value", want.number_value, out_number_value);
          check_field("frame_status", 32'(want.frame_status), 32'(out_frame_status));
        end
      end
      if (in_valid && !in_stall) begin
        if (parse_byte(in_rx_byte, predicted)) begin
          awaited_results.push_back(predicted);
        end
      end
    end
    results_owed = awaited_results.size();
  end

endmodule

`default_nettype wire

### tb/sv/display_response_frame_parser_tb.sv
`default_nettype none

// Top of the frame parser testbench. It builds the clock and reset, sends
// byte transactions into the parser, stalls the result channel at random and
// gives the verdict. All prediction and comparison live in the checker.
module display_response_frame_parser_tb;
  import drfp_pkg::*;

  // The limit is far above what a normal run needs, even with stalls, so only
  // a hang ever reaches it.
  localparam int CYCLE_LIMIT  = 200000;
  // Spare cycles run at the end catch any stray result.
  localparam int DRAIN_CYCLES = 8;
  localparam int BYTE_TARGET  = 450;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic        out_result_kind;
  logic [7:0]  out_string_char;
  logic [7:0]  out_reply_code;
  logic [31:0] out_number_value;
  logic        out_frame_status;

  int fail_count;
  int results_owed;
  int bytes_sent;
  int cycle_count;
  bit idling_on;

  display_response_frame_parser uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_string_char  (out_string_char),
    .out_reply_code   (out_reply_code),
    .out_number_value (out_number_value),
    .out_frame_status (out_frame_status)
  );

  display_response_frame_parser_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_string_char  (out_string_char),
    .out_reply_code   (out_reply_code),
    .out_number_value (out_number_value),
    .out_frame_status (out_frame_status),
    .fail_count       (fail_count),
    .results_owed     (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The result side stalls at random, about ten percent of the time. It holds steady while
  // idling is switched off, which gives a stretch at full throughput.
  always @(negedge clk) begin
    out_stall <= idling_on && ($urandom_range(99) < 10);
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // Sends one byte transaction. The task is entered and left at a falling
  // edge. While idling is on, the sender may first hold valid low at random.
  // Valid then stays high, with the byte steady, until a rising edge finds
  // the parser not stalled.
  task automatic send_byte(input logic [7:0] b);
    while (idling_on && ($urandom_range(99) < 10)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Three terminator bytes. Most are good. The rest are random, so the
  // bad-terminator status gets plenty of hits.
  task automatic send_terminator();
    if ($urandom_range(99) < 85) begin
      repeat (3) send_byte(TERM_BYTE);
    end else begin
      repeat (3) send_byte(8'($urandom_range(255)));
    end
  endtask

  // One random frame. Most frames are well formed with random content, so
  // the parser goes through the number, string and terminator phases. A few
  // loose bytes knock it out of step. The parser has no resync and must
  // recover when the next run of terminators arrives.
  task automatic send_random_frame();
    int roll;
    int n_chars;
    logic [7:0] code;
    roll = $urandom_range(99);
    if (roll < 40) begin
      send_byte(CODE_NUMBER);
      repeat (4) send_byte(8'($urandom_range(255)));
      send_terminator();
    end else if (roll < 75) begin
      send_byte(CODE_STRING);
      n_chars = $urandom_range(8);
      repeat (n_chars) begin
        // A run of one or two 0xFF bytes is sometimes put before a
        // character. The parser must drop it.
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(2, 1)) send_byte(TERM_BYTE);
        end
        send_byte(8'($urandom_range(254)));
      end
      repeat (3) send_byte(TERM_BYTE);
    end else if (roll < 92) begin
      code = 8'($urandom_range(255));
      send_byte(code);
      send_terminator();
    end else begin
      repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    bit paused;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    rst_n      = 1'b0;
    idling_on  = 1'b1;
    bytes_sent = 0;
    paused     = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Number frame. Its byte order shows in the result, and the top byte
    // has its high bit set.
    send_byte(CODE_NUMBER);
    send_byte(8'h04);
    send_byte(8'h03);
    send_byte(8'h02);
    send_byte(8'h81);
    repeat (3) send_byte(TERM_BYTE);

    // String frame. It carries the lowest and highest characters, a lone
    // 0xFF and a pair of 0xFF bytes, both dropped, and then the three-0xFF
    // string end.
    send_byte(CODE_STRING);
    send_byte(8'h00);
    send_byte(TERM_BYTE);
    send_byte(8'h41);
    send_byte(TERM_BYTE);
    send_byte(TERM_BYTE);
    send_byte(8'hFE);
    repeat (3) send_byte(TERM_BYTE);

    // Code 0xFF with a bad terminator. The frame still completes.
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(TERM_BYTE);
    send_byte(TERM_BYTE);

    // Code 0x00 with the bad terminator byte in last place.
    send_byte(8'h00);
    send_byte(TERM_BYTE);
    send_byte(TERM_BYTE);
    send_byte(8'hFE);

    while (bytes_sent < BYTE_TARGET) begin
      // Let the result side drain once in the middle of the run. The sender
      // holds still until every predicted result has been seen.
      if (!paused && bytes_sent >= 200) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_owed != 0) @(negedge clk);
      end
      // A window of back-to-back transactions with no idling on either side.
      idling_on = !(bytes_sent >= 260 && bytes_sent < 360);
      send_random_frame();
    end

    idling_on = 1'b1;
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && results_owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/core/drfp_pkg.sv
rtl/core/drfp_parse.sv
rtl/core/drfp_out_stage.sv
rtl/core/display_response_frame_parser.sv
tb/sv/display_response_frame_parser_checker.sv
tb/sv/display_response_frame_parser_tb.sv
